FILE: hdl/sqlt_pkg.sv
// Shared types and constants for the SQL keyword tokenizer.
// Holds the token kind codes, the lexer mode type, the keyword table and
// the character class helpers. Depends on nothing.
package sqlt_pkg;

  // Token kind codes as they appear on the result port.
  typedef enum logic [4:0] {
    KIND_SELECT  = 5'd0,
    KIND_INSERT  = 5'd1,
    KIND_UPDATE  = 5'd2,
    KIND_DELETE  = 5'd3,
    KIND_FROM    = 5'd4,
    KIND_WHERE   = 5'd5,
    KIND_INTO    = 5'd6,
    KIND_VALUES  = 5'd7,
    KIND_SET     = 5'd8,
    KIND_AND     = 5'd9,
    KIND_OR      = 5'd10,
    KIND_IDENT   = 5'd11,
    KIND_NUMBER  = 5'd12,
    KIND_COMMA   = 5'd13,
    KIND_SEMI    = 5'd14,
    KIND_EQUALS  = 5'd15,
    KIND_STAR    = 5'd16,
    KIND_UNKNOWN = 5'd17,
    KIND_END     = 5'd18
  } token_kind_t;

  // Lexer mode: which kind of run is open, if any.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2
  } lex_mode_t;

  localparam int NUM_KEYWORDS = 11;

  // Keyword text, packed with the last character in the low byte.
  localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
    64'h0000_5345_4C45_4354,  // SELECT
    64'h0000_494E_5345_5254,  // INSERT
    64'h0000_5550_4441_5445,  // UPDATE
    64'h0000_4445_4C45_5445,  // DELETE
    64'h0000_0000_4652_4F4D,  // FROM
    64'h0000_0057_4845_5245,  // WHERE
    64'h0000_0000_494E_544F,  // INTO
    64'h0000_5641_4C55_4553,  // VALUES
    64'h0000_0000_0053_4554,  // SET
    64'h0000_0000_0041_4E44,  // AND
    64'h0000_0000_0000_4F52   // OR
  };

  // Keyword lengths in characters.
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd6, 4'd6, 4'd6, 4'd6, 4'd4, 4'd5, 4'd4, 4'd6, 4'd3, 4'd3, 4'd2
  };

  // Character codes of the single-character tokens and of the blanks.
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Token slots in one bundle, in emission order.
  localparam int SLOT_CLOSE  = 0;
  localparam int SLOT_SINGLE = 1;
  localparam int SLOT_FINAL  = 2;
  localparam int SLOT_END    = 3;
  localparam int NUM_SLOTS   = 4;

  function automatic logic is_letter(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

endpackage

FILE: hdl/sql_keyword_tokenizer.sv
// Top level of the SQL keyword tokenizer: front end, bundle queue, back end.
// Depends on sqlt_pkg, sqlt_front, sqlt_fifo and sqlt_back.
//
// Channel   Direction  Handshake        Payload
// input     in         push / full      byte_value, final_byte
// result    out        pop / empty      token_kind, start_offset, token_length,
//                                       odd_byte, last_of_run
//
// The front end takes one byte per cycle whenever the bundle queue has room.
// Each byte makes a bundle of up to three tokens; the back end sends one token
// per cycle while results are popped, so throughput is one byte per cycle while
// bundles average at most one token; a byte with three tokens holds the back end
// until all three are out. A result goes through the queue and the result register.
// Reset is synchronous and clears the lexer state, queue pointers and result valid bit.
// A stalled result holds the back end; the queue then fills and raises full.
module sql_keyword_tokenizer
  import sqlt_pkg::*;
#(
  parameter int OFFSET_BITS   = 16,
  parameter int KEYWORD_CHARS = 6,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  byte_value,
  input  logic        final_byte,
  input  logic        pop,
  output logic        empty,
  output logic [4:0]  token_kind,
  output logic [15:0] start_offset,
  output logic [15:0] token_length,
  output logic [7:0]  odd_byte,
  output logic        last_of_run
);

  localparam int TOK_W = 13 + 2 * OFFSET_BITS;
  localparam int BUN_W = NUM_SLOTS + NUM_SLOTS * TOK_W;

  logic             accept, bundle_write, head_pop, head_empty;
  logic [BUN_W-1:0] bundle, head;

  // An input transaction completes when push meets a queue with room.
  assign accept = push && !full;

  sqlt_front #(
    .OFFSET_BITS   (OFFSET_BITS),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .byte_value   (byte_value),
    .final_byte   (final_byte),
    .bundle_write (bundle_write),
    .bundle       (bundle)
  );

  sqlt_fifo #(
    .WIDTH (BUN_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (bundle_write),
    .wr_data (bundle),
    .rd      (head_pop),
    .rd_data (head),
    .full    (full),
    .empty   (head_empty)
  );

  sqlt_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_empty   (head_empty),
    .head_pop     (head_pop),
    .pop          (pop),
    .empty        (empty),
    .token_kind   (token_kind),
    .start_offset (start_offset),
    .token_length (token_length),
    .odd_byte     (odd_byte),
    .last_of_run  (last_of_run)
  );

endmodule

FILE: hdl/sqlt_front.sv
// Front end of the SQL keyword tokenizer: takes one byte per cycle while accept is
// high, tracks the open word or number and builds a bundle of up to three tokens.
// Depends on sqlt_pkg.
module sqlt_front
  import sqlt_pkg::*;
#(
  parameter int OFFSET_BITS   = 16,
  parameter int KEYWORD_CHARS = 6,
  localparam int TOK_W = 13 + 2 * OFFSET_BITS,
  localparam int BUN_W = NUM_SLOTS + NUM_SLOTS * TOK_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       byte_value,
  input  logic             final_byte,
  output logic             bundle_write,
  output logic [BUN_W-1:0] bundle
);

  localparam int WORD_W = 8 * KEYWORD_CHARS;
  localparam int OB     = OFFSET_BITS;

  typedef struct packed {
    logic [4:0]    kind;
    logic [OB-1:0] start;
    logic [OB-1:0] len;
    logic [7:0]    odd;
  } token_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]  valid;
    token_t [NUM_SLOTS-1:0] tok;
  } bundle_t;

  // Keyword lookup over the first characters of a word.
  function automatic logic [4:0] word_kind(logic [WORD_W-1:0] chars,
                                           logic [OB-1:0] len,
                                           logic too_long);
    logic [4:0] kind;
    kind = KIND_IDENT;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (!too_long && len == OB'(KW_LEN[k]) && chars == KW_TEXT[k][WORD_W-1:0]) begin
        kind = 5'(k);
      end
    end
    return kind;
  endfunction

  function automatic logic [OB-1:0] sat_inc(logic [OB-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  lex_mode_t         lex_mode, lex_mode_next, mode_step;
  logic [WORD_W-1:0] word_chars, chars_step;
  logic              word_too_long, too_long_step;
  logic [OB-1:0]     run_start, start_step;
  logic [OB-1:0]     run_len, len_step;
  logic [OB-1:0]     byte_position, pos_step;

  logic    letter, digit, blank, extend, single;
  bundle_t bun;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode <= MODE_IDLE;
    end else begin
      lex_mode <= lex_mode_next;
    end
  end

  // Character classes of the incoming byte.
  assign letter = is_letter(byte_value);
  assign digit  = is_digit(byte_value);
  assign blank  = is_blank(byte_value);
  assign extend = (lex_mode == MODE_WORD && (letter || digit)) ||
                  (lex_mode == MODE_NUM && digit);
  assign single = !extend && !blank && !letter && !digit;

  // Next mode and run state after this byte, before the end of statement.
  always_comb begin
    mode_step     = lex_mode;
    chars_step    = word_chars;
    too_long_step = word_too_long;
    start_step    = run_start;
    len_step      = run_len;
    if (extend) begin
      len_step = sat_inc(run_len);
      if (lex_mode == MODE_WORD) begin
        if (run_len >= OB'(KEYWORD_CHARS)) begin
          too_long_step = 1'b1;
        end else begin
          chars_step = {word_chars[WORD_W-9:0], byte_value};
        end
      end
    end else if (letter) begin
      mode_step     = MODE_WORD;
      start_step    = byte_position;
      len_step      = OB'(1);
      chars_step    = WORD_W'(byte_value);
      too_long_step = 1'b0;
    end else if (digit) begin
      mode_step  = MODE_NUM;
      start_step = byte_position;
      len_step   = OB'(1);
    end else begin
      mode_step = MODE_IDLE;
    end
    lex_mode_next = lex_mode;
    if (accept) begin
      lex_mode_next = final_byte ? MODE_IDLE : mode_step;
    end
  end

  assign pos_step = sat_inc(byte_position);

  // Run and position registers; the end of a statement returns them to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_chars    <= '0;
      word_too_long <= 1'b0;
      run_start     <= '0;
      run_len       <= '0;
      byte_position <= '0;
    end else if (accept) begin
      if (final_byte) begin
        word_chars    <= '0;
        word_too_long <= 1'b0;
        run_start     <= '0;
        run_len       <= '0;
        byte_position <= '0;
      end else begin
        word_chars    <= chars_step;
        word_too_long <= too_long_step;
        run_start     <= start_step;
        run_len       <= len_step;
        byte_position <= pos_step;
      end
    end
  end

  // Token bundle: closed run, single character, run closed by the end, end.
  always_comb begin
    bun = '0;

    bun.valid[SLOT_CLOSE]     = !extend && lex_mode != MODE_IDLE;
    bun.tok[SLOT_CLOSE].kind  = (lex_mode == MODE_WORD) ?
                                word_kind(word_chars, run_len, word_too_long) : KIND_NUMBER;
    bun.tok[SLOT_CLOSE].start = run_start;
    bun.tok[SLOT_CLOSE].len   = run_len;

    bun.valid[SLOT_SINGLE]     = single;
    bun.tok[SLOT_SINGLE].start = byte_position;
    bun.tok[SLOT_SINGLE].len   = OB'(1);
    unique case (byte_value)
      CH_COMMA:  bun.tok[SLOT_SINGLE].kind = KIND_COMMA;
      CH_SEMI:   bun.tok[SLOT_SINGLE].kind = KIND_SEMI;
      CH_EQUALS: bun.tok[SLOT_SINGLE].kind = KIND_EQUALS;
      CH_STAR:   bun.tok[SLOT_SINGLE].kind = KIND_STAR;
      default: begin
        bun.tok[SLOT_SINGLE].kind = KIND_UNKNOWN;
        bun.tok[SLOT_SINGLE].odd  = byte_value;
      end
    endcase

    bun.valid[SLOT_FINAL]     = final_byte && mode_step != MODE_IDLE;
    bun.tok[SLOT_FINAL].kind  = (mode_step == MODE_WORD) ?
                                word_kind(chars_step, len_step, too_long_step) : KIND_NUMBER;
    bun.tok[SLOT_FINAL].start = start_step;
    bun.tok[SLOT_FINAL].len   = len_step;

    bun.valid[SLOT_END]     = final_byte;
    bun.tok[SLOT_END].kind  = KIND_END;
    bun.tok[SLOT_END].start = pos_step;
  end

  assign bundle_write = accept && (|bun.valid);
  assign bundle       = bun;

  // A written bundle carries at least one token.
  assert property (@(posedge clk) disable iff (rst)
    bundle_write |-> (|bun.valid))
    else $error("front wrote an empty bundle");

  // The last byte of a statement always produces an end token.
  assert property (@(posedge clk) disable iff (rst)
    (accept && final_byte) |-> (bundle_write && bun.valid[SLOT_END]))
    else $error("final byte without end token");

  // After the last byte the lexer is back at the start of a statement.
  assert property (@(posedge clk) disable iff (rst)
    (accept && final_byte) |=> (lex_mode == MODE_IDLE && byte_position == '0))
    else $error("lexer state not cleared after end of statement");

endmodule

FILE: hdl/sqlt_fifo.sv
// Small bundle queue between the tokenizer front and back ends.
// A register array with read and write pointers and an occupancy count.
// Depends on nothing but its parameters.
module sqlt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (rst) wr |-> !full)
    else $error("write into a full queue");

  assert property (@(posedge clk) disable iff (rst) rd |-> !empty)
    else $error("read from an empty queue");

endmodule

FILE: hdl/sqlt_back.sv
// Back end of the SQL keyword tokenizer: walks the tokens of the head
// bundle one per cycle, while the result is not stalled, into the result register.
// Depends on sqlt_pkg.
module sqlt_back
  import sqlt_pkg::*;
#(
  parameter int OFFSET_BITS = 16,
  localparam int TOK_W = 13 + 2 * OFFSET_BITS,
  localparam int BUN_W = NUM_SLOTS + NUM_SLOTS * TOK_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [BUN_W-1:0] head,
  input  logic             head_empty,
  output logic             head_pop,
  input  logic             pop,
  output logic             empty,
  output logic [4:0]       token_kind,
  output logic [15:0]      start_offset,
  output logic [15:0]      token_length,
  output logic [7:0]       odd_byte,
  output logic             last_of_run
);

  localparam int OB = OFFSET_BITS;

  typedef struct packed {
    logic [4:0]    kind;
    logic [OB-1:0] start;
    logic [OB-1:0] len;
    logic [7:0]    odd;
  } token_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]  valid;
    token_t [NUM_SLOTS-1:0] tok;
  } bundle_t;

  bundle_t              bun;
  logic [NUM_SLOTS-1:0] done, pending, pick, rest;
  token_t               sel, out_tok;
  logic                 out_valid, out_last, load, take;
  logic [OB+15:0]       start_ext, len_ext;

  assign bun = head;

  // Lowest pending slot of the head bundle goes out next.
  assign pending = head_empty ? '0 : (bun.valid & ~done);
  assign pick    = pending & (~pending + 1'b1);
  assign rest    = pending & ~pick;
  assign load    = !out_valid || pop;
  assign take    = load && (|pending);
  assign head_pop = take && (rest == '0);

  always_comb begin
    sel = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (pick[i]) begin
        sel = sel | bun.tok[i];
      end
    end
  end

  // Slot progress within the head bundle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (take) begin
      done <= (rest == '0) ? '0 : (done | pick);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_tok  <= sel;
      out_last <= rest == '0;
    end
  end

  // Offsets are carried at full width and shown in 16 bits.
  assign start_ext    = {16'b0, out_tok.start};
  assign len_ext      = {16'b0, out_tok.len};
  assign empty        = !out_valid;
  assign token_kind   = out_tok.kind;
  assign start_offset = start_ext[15:0];
  assign token_length = len_ext[15:0];
  assign odd_byte     = out_tok.odd;
  assign last_of_run  = out_last;

  assert property (@(posedge clk) disable iff (rst) $onehot0(pick))
    else $error("more than one slot picked");

  assert property (@(posedge clk) disable iff (rst) (|done) |-> !head_empty)
    else $error("partly sent bundle lost from queue head");

  assert property (@(posedge clk) disable iff (rst) head_pop |=> (out_valid && out_last))
    else $error("bundle retired without its last transaction");

endmodule

FILE: dv/sqlt_checker.sv
// Result checker for the SQL keyword tokenizer testbench.
// Watches the byte and token channels, predicts the tokens of each byte and
// compares them in order. Depends on sqlt_pkg.
`timescale 1ns / 100ps

module sqlt_checker
  import sqlt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  byte_value,
  input  logic        final_byte,
  input  logic        pop,
  input  logic        empty,
  input  logic [4:0]  token_kind,
  input  logic [15:0] start_offset,
  input  logic [15:0] token_length,
  input  logic [7:0]  odd_byte,
  input  logic        last_of_run,
  output int          errors,
  output int          pending
);

  localparam logic [15:0] OFFSET_MAX = 16'hFFFF;
  localparam int WORD_CHARS = 6;
  localparam int MAX_REPORTS = 30;

  typedef struct {
    token_kind_t kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [7:0]  odd;
    logic        last;
  } token_t;

  // Tokens predicted but not yet seen on the result side, oldest first.
  token_t expected_tokens[$];

  // Private copy of the lexer state.
  lex_mode_t   cur_mode;
  logic [47:0] word_text;
  logic        word_overlong;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [15:0] next_offset;
  int          error_count = 0;

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == OFFSET_MAX) ? v : v + 16'd1;
  endfunction

  function automatic logic alpha_char(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic digit_char(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic space_char(logic [7:0] b);
    return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic void clear_lexer();
    cur_mode = MODE_IDLE;
    word_text = '0;
    word_overlong = 1'b0;
    tok_start = '0;
    tok_len = '0;
    next_offset = '0;
  endfunction

  // A word only matches a keyword when it is short enough to be held whole.
  function automatic token_kind_t word_kind();
    if (word_overlong || tok_len > 16'(WORD_CHARS)) return KIND_IDENT;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if ({16'h0000, word_text} == KW_TEXT[k] && tok_len == 16'(KW_LEN[k]))
        return token_kind_t'(k);
    end
    return KIND_IDENT;
  endfunction

  function automatic void add_token(token_kind_t kind, logic [15:0] start,
                                    logic [15:0] len, logic [7:0] odd);
    token_t tok;
    tok = '{kind, start, len, odd, 1'b0};
    expected_tokens.insert(expected_tokens.size(), tok);
  endfunction

  function automatic void close_run();
    if (cur_mode == MODE_WORD) add_token(word_kind(), tok_start, tok_len, 8'h00);
    else if (cur_mode == MODE_NUM) add_token(KIND_NUMBER, tok_start, tok_len, 8'h00);
    cur_mode = MODE_IDLE;
  endfunction

  // Predict every token caused by one accepted byte.
  function automatic void lex_byte(logic [7:0] b, logic fin);
    logic [15:0] pos;
    int before_count;
    pos = next_offset;
    before_count = expected_tokens.size();
    if (cur_mode == MODE_WORD && (alpha_char(b) || digit_char(b))) begin
      if (tok_len >= 16'(WORD_CHARS)) word_overlong = 1'b1;
      else word_text = {word_text[39:0], b};
      tok_len = sat_inc(tok_len);
    end else if (cur_mode == MODE_NUM && digit_char(b)) begin
      tok_len = sat_inc(tok_len);
    end else begin
      close_run();
      if (space_char(b)) begin
        // Whitespace only separates runs.
      end else if (alpha_char(b)) begin
        cur_mode = MODE_WORD;
        tok_start = pos;
        tok_len = 16'd1;
        word_text = {40'h0, b};
        word_overlong = 1'b0;
      end else if (digit_char(b)) begin
        cur_mode = MODE_NUM;
        tok_start = pos;
        tok_len = 16'd1;
      end else begin
        case (b)
          CH_COMMA:  add_token(KIND_COMMA, pos, 16'd1, 8'h00);
          CH_SEMI:   add_token(KIND_SEMI, pos, 16'd1, 8'h00);
          CH_EQUALS: add_token(KIND_EQUALS, pos, 16'd1, 8'h00);
          CH_STAR:   add_token(KIND_STAR, pos, 16'd1, 8'h00);
          default:   add_token(KIND_UNKNOWN, pos, 16'd1, b);
        endcase
      end
    end
    next_offset = sat_inc(pos);
    // The last byte closes the statement and starts the next one at zero.
    if (fin) begin
      close_run();
      add_token(KIND_END, next_offset, 16'd0, 8'h00);
      clear_lexer();
    end
    if (expected_tokens.size() > before_count)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endfunction

  function automatic void report(string what, token_t exp_tok);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s: expected kind %0d start %0d len %0d odd %0d last %0d, %s",
               $time, what, exp_tok.kind, exp_tok.start, exp_tok.len, exp_tok.odd,
               exp_tok.last,
               $sformatf("got kind %0d start %0d len %0d odd %0d last %0d",
                         token_kind, start_offset, token_length, odd_byte,
                         last_of_run));
  endfunction

  // Compare each token transaction, then predict from each byte transaction.
  always @(posedge clk) begin
    token_t exp_tok;
    if (rst) begin
      clear_lexer();
      expected_tokens.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_tokens.size() == 0) begin
          exp_tok = '{KIND_END, 16'h0, 16'h0, 8'h0, 1'b0};
          report("token with none expected", exp_tok);
        end else begin
          exp_tok = expected_tokens.pop_front();
          if (token_kind !== exp_tok.kind || start_offset !== exp_tok.start ||
              token_length !== exp_tok.len || odd_byte !== exp_tok.odd ||
              last_of_run !== exp_tok.last)
            report("token mismatch", exp_tok);
        end
      end
      if (push && !full) lex_byte(byte_value, final_byte);
    end
    pending <= expected_tokens.size();
    errors <= error_count;
  end

endmodule

FILE: dv/testbench.sv
// Top of the SQL keyword tokenizer testbench: clock, reset, byte stimulus,
// token receiver and verdict. Depends on sqlt_pkg, sqlt_checker and the RTL.
`timescale 1ns / 100ps

module testbench;
  import sqlt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES = 380;
  localparam int TAIL_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  byte_value = 8'h00;
  logic        final_byte = 1'b0;
  logic        pop = 1'b0;
  logic        empty;
  logic [4:0]  token_kind;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic [7:0]  odd_byte;
  logic        last_of_run;
  int          errors;
  int          pending;

  string keyword_names [NUM_KEYWORDS] = '{
    "SELECT", "INSERT", "UPDATE", "DELETE", "FROM", "WHERE",
    "INTO", "VALUES", "SET", "AND", "OR"
  };

  sql_keyword_tokenizer u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .byte_value   (byte_value),
    .final_byte   (final_byte),
    .pop          (pop),
    .empty        (empty),
    .token_kind   (token_kind),
    .start_offset (start_offset),
    .token_length (token_length),
    .odd_byte     (odd_byte),
    .last_of_run  (last_of_run)
  );

  sqlt_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .byte_value   (byte_value),
    .final_byte   (final_byte),
    .pop          (pop),
    .empty        (empty),
    .token_kind   (token_kind),
    .start_offset (start_offset),
    .token_length (token_length),
    .odd_byte     (odd_byte),
    .last_of_run  (last_of_run),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: phases of steady popping, coin-flip popping and sparse popping.
  int pop_phase_left = 0;
  int pop_mode = 0;
  int pop_period = 4;
  int pop_tick = 0;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop_phase_left == 0) begin
        pop_mode = $urandom_range(0, 2);
        pop_period = $urandom_range(2, 8);
        pop_phase_left = $urandom_range(16, 200);
      end
      pop_phase_left--;
      pop_tick++;
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        default: pop <= (pop_tick % pop_period) == 0;
      endcase
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Sender state: bytes left in the current burst, bytes sent and the statement bytes.
  int burst_left = 0;
  int bytes_sent = 0;
  logic [7:0] stmt_bytes[$];

  // Append one byte to the statement being built.
  function automatic void add_byte(logic [7:0] b);
    stmt_bytes.insert(stmt_bytes.size(), b);
  endfunction

  // Offer one byte and wait for the block to take it.
  task automatic send_byte(logic [7:0] b, logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    byte_value <= b;
    final_byte <= fin;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic send_text(string s, logic fin_on_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], fin_on_last && (i == s.len() - 1));
  endtask

  // Hold the sender off until every predicted token has come out.
  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic append_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] blank_byte();
    return ($urandom_range(0, 2) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] punct_byte();
    case ($urandom_range(0, 3))
      0: return CH_COMMA;
      1: return CH_SEMI;
      2: return CH_EQUALS;
      default: return CH_STAR;
    endcase
  endfunction

  // Build one statement from random pieces and send it, final on the last byte.
  task automatic random_statement();
    int pieces;
    int n;
    string word;
    stmt_bytes.delete();
    pieces = $urandom_range(1, 12);
    for (int p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          word = keyword_names[$urandom_range(0, NUM_KEYWORDS - 1)];
          case ($urandom_range(0, 7))
            0, 1: word = word.tolower();
            2: word = word.substr(0, word.len() - 2);
            3: word = {word, "S"};
            default: ;
          endcase
          append_text(word);
        end
        3: begin
          n = $urandom_range(1, 9);
          add_byte(($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25)));
          for (int i = 1; i < n; i++)
            add_byte($urandom_range(0, 2) == 0 ?
                     "0" + 8'($urandom_range(0, 9)) :
                     "a" + 8'($urandom_range(0, 25)));
        end
        4: begin
          n = $urandom_range(1, 7);
          for (int i = 0; i < n; i++) add_byte("0" + 8'($urandom_range(0, 9)));
        end
        5: add_byte(punct_byte());
        6: add_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) :
                    8'($urandom_range(128, 255)));
        7: add_byte(blank_byte());
        default: add_byte(CH_SPACE);
      endcase
      // Most pieces are separated so that keywords stand on their own.
      case ($urandom_range(0, 5))
        0, 1, 2: add_byte(blank_byte());
        3: add_byte(punct_byte());
        default: ;
      endcase
    end
    foreach (stmt_bytes[i]) send_byte(stmt_bytes[i], i == stmt_bytes.size() - 1);
  endtask

  // Noise: arbitrary bytes, sometimes ending a statement in the middle of a run.
  task automatic noise_run();
    int n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty statement, operators, byte extremes, long word,
    // three tokens from one byte, and a keyword closed by the final byte.
    send_byte(CH_TAB, 1'b1);
    send_text("OR=42;", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0C, 1'b0);
    send_text("Abcdefg,", 1'b1);
    send_text("7*", 1'b1);
    send_text("SELECT", 1'b1);
    drain();

    // Random statements with some noise mixed in.
    while (bytes_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 6) == 0) noise_run();
      else random_statement();
    end
    drain();

    // A mixed-case keyword in the middle and a word closed by the final byte.
    send_text(" ab,Where x", 1'b1);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
